>>> hw/rtl/dopt_pkg.sv
// Types and constants shared by the DHCP option parser files.
`timescale 1ns / 1ps

package dopt_pkg;

	localparam logic [7:0] CODE_PAD     = 8'd0;
	localparam logic [7:0] CODE_MASK    = 8'd1;
	localparam logic [7:0] CODE_ROUTER  = 8'd3;
	localparam logic [7:0] CODE_DNS     = 8'd6;
	localparam logic [7:0] CODE_MSGTYPE = 8'd53;
	localparam logic [7:0] CODE_SERVER  = 8'd54;
	localparam logic [7:0] CODE_END     = 8'd255;

	typedef enum logic [3:0] {
		PH_CODE  = 4'b0001,
		PH_LEN   = 4'b0010,
		PH_VALUE = 4'b0100,
		PH_DONE  = 4'b1000
	} dopt_phase_t;

	typedef struct packed {
		logic [7:0]  msg_kind;
		logic        msg_kind_found;
		logic [31:0] subnet_mask;
		logic        mask_found;
		logic [31:0] router_addr;
		logic        router_found;
		logic [31:0] dns_addr;
		logic        dns_found;
		logic [31:0] server_ident;
		logic        server_found;
		logic        end_seen;
		logic        truncated;
	} dopt_result_t;

	typedef struct packed {
		dopt_phase_t phase;
		logic [7:0]  code;
		logic [7:0]  bytes_left;
		logic [2:0]  value_index;
		logic [31:0] value_shift;
		logic [7:0]  held_msg_kind;
		logic [31:0] held_mask;
		logic [31:0] held_router;
		logic [31:0] held_dns;
		logic [31:0] held_server;
		logic        found_msg;
		logic        found_mask;
		logic        found_router;
		logic        found_dns;
		logic        found_server;
		logic        end_seen;
		logic        truncated;
	} dopt_state_t;

	localparam dopt_state_t DOPT_STATE_RST = '{
		phase:         PH_CODE,
		code:          8'd0,
		bytes_left:    8'd0,
		value_index:   3'd0,
		value_shift:   32'd0,
		held_msg_kind: 8'd0,
		held_mask:     32'd0,
		held_router:   32'd0,
		held_dns:      32'd0,
		held_server:   32'd0,
		found_msg:     1'b0,
		found_mask:    1'b0,
		found_router:  1'b0,
		found_dns:     1'b0,
		found_server:  1'b0,
		end_seen:      1'b0,
		truncated:     1'b0
	};

endpackage

>>> hw/rtl/dopt_in_if.sv
// Input channel: one options byte per item with a last-byte mark.
`timescale 1ns / 1ps

interface dopt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] opt_byte;
	logic       last_byte;

	modport source (output valid, output opt_byte, output last_byte, input ready);
	modport sink   (input valid, input opt_byte, input last_byte, output ready);
endinterface

>>> hw/rtl/dopt_out_if.sv
// Result channel: the captured option values of one options area.
`timescale 1ns / 1ps

interface dopt_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  msg_kind;
	logic        msg_kind_found;
	logic [31:0] subnet_mask;
	logic        mask_found;
	logic [31:0] router_addr;
	logic        router_found;
	logic [31:0] dns_addr;
	logic        dns_found;
	logic [31:0] server_ident;
	logic        server_found;
	logic        end_seen;
	logic        truncated;

	modport source (
		output valid, output msg_kind, output msg_kind_found, output subnet_mask,
		output mask_found, output router_addr, output router_found, output dns_addr,
		output dns_found, output server_ident, output server_found, output end_seen,
		output truncated, input ready
	);
	modport sink (
		input valid, input msg_kind, input msg_kind_found, input subnet_mask,
		input mask_found, input router_addr, input router_found, input dns_addr,
		input dns_found, input server_ident, input server_found, input end_seen,
		input truncated, output ready
	);
endinterface

>>> hw/rtl/dhcp_option_tlv_parser.sv
// Top level of the DHCP option TLV parser: walker plus two-entry result queue.
`timescale 1ns / 1ps

// Channel | Dir | Payload                                   | Item
// opts    | in  | opt_byte[7:0], last_byte                  | one options byte
// summary | out | msg_kind, mask/router/dns/server values,   | one per options area,
//         |     | found flags, end_seen, truncated          | on the last byte
//
// One byte is taken per clock while opts.ready is high; the walker updates
// its parse state in the same cycle and a last byte queues a result, pending
// the next cycle. Results queue in an output register plus one skid entry, so
// bytes keep flowing while a result waits; opts.ready drops only when the
// skid entry is occupied. arst_n clears the parse state and both queue valid
// flags. After each last byte the parse state returns to its reset value.

module dhcp_option_tlv_parser (
	input  logic          clk,
	input  logic          arst_n,
	dopt_in_if.sink       opts,
	dopt_out_if.source    summary
);
	import dopt_pkg::*;

	dopt_result_t res_new;
	dopt_result_t out_q;
	dopt_result_t skid_q;
	logic         out_valid_q;
	logic         skid_valid_q;
	logic         in_take;
	logic         emit;
	logic         out_take;

	assign opts.ready = !skid_valid_q;
	assign in_take    = opts.valid && opts.ready;
	assign emit       = in_take && opts.last_byte;
	assign out_take   = out_valid_q && summary.ready;

	dopt_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (in_take),
		.opt_byte  (opts.opt_byte),
		.last_byte (opts.last_byte),
		.res       (res_new)
	);

	// queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_take || !out_valid_q) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= emit;
				end
			end else if (emit) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// queue payload
	always_ff @(posedge clk) begin
		if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (emit) begin
				out_q <= res_new;
			end
		end else if (emit) begin
			skid_q <= res_new;
		end
	end

	assign summary.valid          = out_valid_q;
	assign summary.msg_kind       = out_q.msg_kind;
	assign summary.msg_kind_found = out_q.msg_kind_found;
	assign summary.subnet_mask    = out_q.subnet_mask;
	assign summary.mask_found     = out_q.mask_found;
	assign summary.router_addr    = out_q.router_addr;
	assign summary.router_found   = out_q.router_found;
	assign summary.dns_addr       = out_q.dns_addr;
	assign summary.dns_found      = out_q.dns_found;
	assign summary.server_ident   = out_q.server_ident;
	assign summary.server_found   = out_q.server_found;
	assign summary.end_seen       = out_q.end_seen;
	assign summary.truncated      = out_q.truncated;

	// skid entry is only used behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty output register");

	// a last byte always yields a pending result next cycle
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("accepted last byte produced no result");

	// a result arriving at a stalled output goes to the skid entry
	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && out_valid_q && !summary.ready) |=> skid_valid_q)
		else $error("result lost behind stalled output");

	// a held result leaves only through a handshake
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !summary.ready) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled result changed");

endmodule

>>> hw/rtl/dopt_walker.sv
// TLV walker: parse state register and the per-byte next-state logic.
`timescale 1ns / 1ps

module dopt_walker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            opt_byte,
	input  logic                  last_byte,
	output dopt_pkg::dopt_result_t res
);
	import dopt_pkg::*;

	dopt_state_t st_q;
	dopt_state_t nx;
	logic [31:0] lane;
	logic        apply;

	always_comb begin
		nx    = st_q;
		lane  = 32'd0;
		apply = 1'b0;
		unique case (st_q.phase)
			PH_CODE: begin
				if (opt_byte == CODE_END) begin
					nx.end_seen = 1'b1;
					nx.phase    = PH_DONE;
				end else if (opt_byte != CODE_PAD) begin
					nx.code  = opt_byte;
					nx.phase = PH_LEN;
					if (last_byte) nx.truncated = 1'b1;
				end
			end
			PH_LEN: begin
				nx.value_index = 3'd0;
				nx.value_shift = 32'd0;
				nx.bytes_left  = opt_byte;
				// zero length: nothing can qualify, back to code
				if (opt_byte == 8'd0) begin
					nx.phase = PH_CODE;
				end else begin
					nx.phase = PH_VALUE;
					if (last_byte) nx.truncated = 1'b1;
				end
			end
			PH_VALUE: begin
				// keep the first four value bytes, first byte in bits 7:0
				if (!st_q.value_index[2]) begin
					lane = {24'd0, opt_byte} << {st_q.value_index[1:0], 3'b000};
					nx.value_shift = st_q.value_shift | lane;
					nx.value_index = st_q.value_index + 3'd1;
				end
				nx.bytes_left = st_q.bytes_left - 8'd1;
				if (nx.bytes_left == 8'd0) begin
					apply    = 1'b1;
					nx.phase = PH_CODE;
				end else if (last_byte) begin
					nx.truncated = 1'b1;
				end
			end
			PH_DONE: begin
			end
			default: begin
				nx.phase = PH_CODE;
			end
		endcase

		if (apply) begin
			case (st_q.code)
				CODE_MSGTYPE: begin
					if (nx.value_index != 3'd0) begin
						nx.held_msg_kind = nx.value_shift[7:0];
						nx.found_msg     = 1'b1;
					end
				end
				CODE_MASK: begin
					if (nx.value_index[2]) begin
						nx.held_mask  = nx.value_shift;
						nx.found_mask = 1'b1;
					end
				end
				CODE_ROUTER: begin
					if (nx.value_index[2]) begin
						nx.held_router  = nx.value_shift;
						nx.found_router = 1'b1;
					end
				end
				CODE_DNS: begin
					if (nx.value_index[2]) begin
						nx.held_dns  = nx.value_shift;
						nx.found_dns = 1'b1;
					end
				end
				CODE_SERVER: begin
					if (nx.value_index[2]) begin
						nx.held_server  = nx.value_shift;
						nx.found_server = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result reflects the state after the current byte
	always_comb begin
		res.msg_kind       = nx.held_msg_kind;
		res.msg_kind_found = nx.found_msg;
		res.subnet_mask    = nx.held_mask;
		res.mask_found     = nx.found_mask;
		res.router_addr    = nx.held_router;
		res.router_found   = nx.found_router;
		res.dns_addr       = nx.held_dns;
		res.dns_found      = nx.found_dns;
		res.server_ident   = nx.held_server;
		res.server_found   = nx.found_server;
		res.end_seen       = nx.end_seen;
		res.truncated      = nx.truncated;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= DOPT_STATE_RST;
		end else if (step) begin
			st_q <= last_byte ? DOPT_STATE_RST : nx;
		end
	end

endmodule
